// File: src/mrr_pkg.sv
// Shared types, codes and the CRC-16 byte fold for the Modbus RTU response receiver.
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

  // Default depth of the register word store
  localparam int MAX_REGISTERS_DEFAULT = 16;

  // Frame bytes besides the register words: address, function, byte count, two CRC bytes
  localparam int FRAME_OVERHEAD = 5;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Input opcodes
  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE    = 2'd0;
  localparam logic [1:0] CFG_FUNCTION = 2'd1;
  localparam logic [1:0] CFG_COUNT    = 2'd2;

  // Configuration handed to the parser
  typedef struct packed {
    logic [7:0] expected_slave;
    logic [7:0] expected_function;
    logic [4:0] register_count;
  } cfg_t;

  // Receiver control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RECV,
    S_READ,
    S_LOAD
  } fsm_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/modbus_rtu_response_receiver.sv
// A status result is registered for output the cycle after its final word is taken.
// A good frame emits its registers from the word store, each by a store read, then an
// output load; input is held off until the last one is loaded. Throughput: one input
// word per cycle while receiving and the output is free, set by the single parser update.
// Reset (rst, synchronous): receiver idle, config back to slave 1, function 3, 2 registers.
// The word store is not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver
  import mrr_pkg::*;
#(
  parameter int MAX_REGISTERS = MAX_REGISTERS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  status,
  output logic      [3:0]  register_index,
  output logic      [15:0] register_value,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_slave    <= 8'd1;
      cfg.expected_function <= 8'd3;
      cfg.register_count    <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE:    cfg.expected_slave    <= cfg_data;
        CFG_FUNCTION: cfg.expected_function <= cfg_data;
        CFG_COUNT:    cfg.register_count    <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  mrr_parser #(
    .MAX_REGISTERS (MAX_REGISTERS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .register_index (register_index),
    .register_value (register_value),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: src/mrr_store.sv
// Register word store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mrr_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/mrr_parser.sv
// Frame parser: address hunt, byte counting, CRC, word storage and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module mrr_parser
  import mrr_pkg::*;
#(
  parameter int MAX_REGISTERS = MAX_REGISTERS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  status,
  output logic      [3:0]  register_index,
  output logic      [15:0] register_value,
  output logic             last
);

  localparam int AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam logic [4:0] MAX_N = 5'(MAX_REGISTERS);

  // Control and frame state
  fsm_t        state, state_next;
  logic [5:0]  bytes_received, bytes_received_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_hi, held_hi_next;
  logic [7:0]  high_byte_latch, high_byte_latch_next;
  logic [4:0]  emit_cnt, emit_cnt_next;

  // Store port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_q;

  // Output word load
  logic        load;
  logic [1:0]  ld_status;
  logic [3:0]  ld_index;
  logic [15:0] ld_value;
  logic        ld_last;

  // Frame geometry
  logic [4:0] num;
  logic [5:0] frame_len;
  logic [5:0] word_pos;
  logic [5:0] cnt_inc;
  logic       in_body;
  logic       out_free;
  logic       accept;

  mrr_store #(
    .DEPTH (MAX_REGISTERS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (emit_cnt[AW-1:0]),
    .rdata (mem_q)
  );

  assign num       = (cfg.register_count > MAX_N) ? MAX_N : cfg.register_count;
  assign frame_len = 6'(FRAME_OVERHEAD) + {num, 1'b0};
  assign word_pos  = bytes_received - 6'd3;
  assign cnt_inc   = bytes_received + 6'd1;
  assign in_body   = ({1'b0, bytes_received} + 7'd2) < {1'b0, frame_len};
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = ((state == S_IDLE) || (state == S_RECV)) && out_free;
  assign accept    = in_valid && in_ready;
  assign mem_waddr = word_pos[AW:1];
  assign mem_wdata = {high_byte_latch, rx_byte};

  // Next state and per-word actions
  always_comb begin
    state_next           = state;
    bytes_received_next  = bytes_received;
    running_crc_next     = running_crc;
    held_hi_next         = held_hi;
    high_byte_latch_next = high_byte_latch;
    emit_cnt_next        = emit_cnt;
    mem_we               = 1'b0;
    mem_re               = 1'b0;
    load                 = 1'b0;
    ld_status            = ST_GOOD;
    ld_index             = 4'd0;
    ld_value             = 16'd0;
    ld_last              = 1'b1;

    case (state)
      S_IDLE, S_RECV: begin
        if (accept) begin
          case (opcode)
            OP_BEGIN: begin
              state_next           = S_RECV;
              bytes_received_next  = 6'd0;
              running_crc_next     = CRC_INIT;
              held_hi_next         = 8'd0;
              high_byte_latch_next = 8'd0;
            end
            OP_TIMEOUT: begin
              if (state == S_RECV) begin
                state_next = S_IDLE;
                load       = 1'b1;
                ld_status  = ST_TIMEOUT;
              end
            end
            OP_BYTE: begin
              if (state == S_RECV) begin
                if ((bytes_received == 6'd0) && (rx_byte != cfg.expected_slave)) begin
                  // still hunting for the address
                end else if ((bytes_received == 6'd1) &&
                             (rx_byte != cfg.expected_function)) begin
                  // wrong function: restart, maybe with this byte as address
                  bytes_received_next  = 6'd0;
                  running_crc_next     = CRC_INIT;
                  held_hi_next         = 8'd0;
                  high_byte_latch_next = 8'd0;
                  if (rx_byte == cfg.expected_slave) begin
                    running_crc_next    = crc_fold(CRC_INIT, rx_byte);
                    bytes_received_next = 6'd1;
                  end
                end else begin
                  if (in_body) begin
                    running_crc_next = crc_fold(running_crc, rx_byte);
                    if (bytes_received >= 6'd3) begin
                      if (!word_pos[0]) begin
                        high_byte_latch_next = rx_byte;
                      end else begin
                        mem_we = 1'b1;
                      end
                    end
                  end else begin
                    held_hi_next = rx_byte;
                  end
                  bytes_received_next = cnt_inc;
                  // frame complete; CRC is final here since tail bytes do not fold
                  if (cnt_inc >= frame_len) begin
                    state_next = S_IDLE;
                    if (running_crc != {rx_byte, held_hi}) begin
                      load      = 1'b1;
                      ld_status = ST_CRC_ERR;
                    end else if (num == 5'd0) begin
                      load = 1'b1;
                    end else begin
                      emit_cnt_next = 5'd0;
                      state_next    = S_READ;
                    end
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load     = 1'b1;
          ld_index = emit_cnt[3:0];
          ld_value = mem_q;
          ld_last  = (5'(emit_cnt + 5'd1) == num);
          if (ld_last) begin
            state_next = S_IDLE;
          end else begin
            emit_cnt_next = emit_cnt + 5'd1;
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      bytes_received  <= 6'd0;
      running_crc     <= CRC_INIT;
      held_hi         <= 8'd0;
      high_byte_latch <= 8'd0;
      emit_cnt        <= 5'd0;
    end else begin
      state           <= state_next;
      bytes_received  <= bytes_received_next;
      running_crc     <= running_crc_next;
      held_hi         <= held_hi_next;
      high_byte_latch <= high_byte_latch_next;
      emit_cnt        <= emit_cnt_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= ld_status;
      register_index <= ld_index;
      register_value <= ld_value;
      last           <= ld_last;
    end
  end

endmodule

`default_nettype wire
